>>> rtl/ftsa_pkg.sv
// Shared types, codes and sizes for the fixed-timestep accumulator.
`timescale 1ns / 1ps

package ftsa_pkg;

  // Field and register widths
  localparam int STEP_W      = 20;  // fixed_step_us
  localparam int MAX_DELTA_W = 23;  // max_frame_delta_us, unscaled delta
  localparam int MAX_STEPS_W = 8;   // max_steps_per_frame, step count
  localparam int SCALE_W     = 16;  // Q8.8 time scale
  localparam int RAW_DELTA_W = 24;  // signed input delta
  localparam int DELTA_W     = 31;  // scaled delta
  localparam int TOTAL_W     = 48;
  localparam int FRAMES_W    = 40;
  localparam int ALPHA_W     = 16;
  localparam int CREDIT_W    = 28;
  localparam int CFG_W       = 23;
  localparam int CFG_IDX_W   = 2;
  localparam int SCALE_FRAC  = 8;

  // Serial multiplier: MUL_A_W x MUL_B_W, one multiplier bit per cycle
  localparam int MUL_A_W   = MAX_DELTA_W;
  localparam int MUL_B_W   = SCALE_W;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // Serial divider: one quotient bit per cycle
  localparam int DIV_Q_W   = ALPHA_W;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  localparam logic [STEP_W-1:0]      RST_FIXED_STEP = STEP_W'(16667);
  localparam logic [MAX_DELTA_W-1:0] RST_MAX_DELTA  = MAX_DELTA_W'(250000);
  localparam logic [MAX_STEPS_W-1:0] RST_MAX_STEPS  = MAX_STEPS_W'(8);
  localparam logic [SCALE_W-1:0]     RST_MAX_SCALE  = SCALE_W'(25600);
  localparam logic [SCALE_W-1:0]     SCALE_ONE      = SCALE_W'(256);

  typedef enum logic [2:0] {
    OP_FRAME   = 3'd0,
    OP_PLAY    = 3'd1,
    OP_STOP    = 3'd2,
    OP_PAUSE   = 3'd3,
    OP_RESUME  = 3'd4,
    OP_DISCARD = 3'd5,
    OP_RESET   = 3'd6,
    OP_SCALE   = 3'd7
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIXED_STEP = 2'd0,
    CFG_MAX_DELTA  = 2'd1,
    CFG_MAX_STEPS  = 2'd2,
    CFG_MAX_SCALE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_DELTA,
    S_MUL_CAP,
    S_DIV_STEPS,
    S_ALPHA_START,
    S_ALPHA_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]                    op;
    logic signed [RAW_DELTA_W-1:0] delta_us;
    logic signed [SCALE_W-1:0]     scale_q8;
  } in_item_t;

  typedef struct packed {
    logic [DELTA_W-1:0]     delta_us_res;
    logic [MAX_DELTA_W-1:0] unscaled_delta_us;
    logic [MAX_STEPS_W-1:0] fixed_steps;
    logic [TOTAL_W-1:0]     time_us;
    logic [TOTAL_W-1:0]     unscaled_time_us;
    logic [FRAMES_W-1:0]    frame_count;
    logic [ALPHA_W-1:0]     alpha_q16;
    logic                   is_playing;
    logic                   is_paused;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] product;
  } mul_res_t;

  typedef struct packed {
    logic                 start;
    logic [STEP_W-1:0]    divisor;
    logic [STEP_W-1:0]    rem_init;  // must be below divisor
    logic [DIV_Q_W-1:0]   low_bits;  // dividend bits fed in, msb first
    logic [DIV_CNT_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quotient;
    logic [STEP_W-1:0]  remainder;
  } div_res_t;

endpackage

>>> rtl/fixed_timestep_accumulator_core.sv
// Top level of the fixed-timestep accumulator: command decode, run state and sequencing.
`timescale 1ns / 1ps

// Fixed-timestep accumulator. Each transfer on the input channel is a frame event
// (op 0, with a signed microsecond delta) or a command (begin play, stop, pause,
// resume, discard pending steps, reset, set time scale), and each one gives exactly
// one result transfer with the current deltas, step count, totals, Q0.16
// interpolation alpha and play flags. Items are handled one at a time. A command,
// or a frame outside unpaused play, goes from idle through the alpha step to the
// result, with an alpha division when a step is set and the credit holds less
// than a whole step. A frame during unpaused play first runs two passes of one
// bit-serial 23x16 multiplier (scaled delta, then the credit cap) and, with a
// nonzero step, the step count on one shared restoring divider that alpha uses too.
// The result sits in an output register, so the next item is taken while a result
// still waits. Configuration writes land at once and are to be made only while idle.

module fixed_timestep_accumulator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ftsa_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ftsa_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [ftsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ftsa_pkg::CFG_W-1:0]        cfg_data
);

  // Configuration registers
  logic [ftsa_pkg::STEP_W-1:0]      fixed_step;
  logic [ftsa_pkg::MAX_DELTA_W-1:0] max_delta;
  logic [ftsa_pkg::MAX_STEPS_W-1:0] max_steps;
  logic [ftsa_pkg::SCALE_W-1:0]     max_scale;

  // Run state
  logic                             playing;
  logic                             paused;
  logic [ftsa_pkg::SCALE_W-1:0]     time_scale;
  logic [ftsa_pkg::CREDIT_W-1:0]    credit;
  logic [ftsa_pkg::TOTAL_W-1:0]     scaled_total;
  logic [ftsa_pkg::TOTAL_W-1:0]     unscaled_total;
  logic [ftsa_pkg::FRAMES_W-1:0]    frames;
  logic [ftsa_pkg::DELTA_W-1:0]     last_delta;
  logic [ftsa_pkg::MAX_DELTA_W-1:0] last_unscaled;
  logic [ftsa_pkg::MAX_STEPS_W-1:0] last_steps;
  logic [ftsa_pkg::ALPHA_W-1:0]     alpha;

  ftsa_pkg::state_t   state;
  ftsa_pkg::state_t   state_next;
  ftsa_pkg::mul_req_t mul_req;
  ftsa_pkg::mul_res_t mul_res;
  ftsa_pkg::div_req_t div_req;
  ftsa_pkg::div_res_t div_res;

  logic                             accept;
  logic                             frame_go;
  logic                             out_load;
  logic                             step_zero;
  logic [ftsa_pkg::MAX_DELTA_W-1:0] frame_delta;
  logic [ftsa_pkg::MAX_DELTA_W-1:0] sim_delta;
  logic [ftsa_pkg::SCALE_W-1:0]     scale_req;
  logic [ftsa_pkg::SCALE_W-1:0]     scale_clamped;
  logic [ftsa_pkg::DELTA_W-1:0]     prod_delta;
  logic [ftsa_pkg::CREDIT_W-1:0]    credit_cap;
  logic [ftsa_pkg::DELTA_W:0]       credit_sum;
  logic [ftsa_pkg::CREDIT_W-1:0]    credit_sat;

  assign accept    = in_valid && !in_stall;
  assign out_load  = (state == ftsa_pkg::S_DONE) && !(out_valid && out_stall);
  assign step_zero = (fixed_step == '0);

  // A frame runs the multiply path only while playing and not paused
  assign frame_go = (ftsa_pkg::op_t'(in_data.op) == ftsa_pkg::OP_FRAME) && playing && !paused;

  // Drop negative deltas, then cap for simulation
  assign frame_delta = in_data.delta_us[ftsa_pkg::RAW_DELTA_W-1] ? '0 :
                       in_data.delta_us[ftsa_pkg::MAX_DELTA_W-1:0];
  assign sim_delta   = (frame_delta < max_delta) ? frame_delta : max_delta;

  // Negative scale requests clamp to zero, large ones to the register
  assign scale_req     = $unsigned(in_data.scale_q8);
  assign scale_clamped = in_data.scale_q8[ftsa_pkg::SCALE_W-1] ? '0 :
                         ((scale_req < max_scale) ? scale_req : max_scale);

  // Scaled delta drops the Q8.8 fraction
  assign prod_delta = mul_res.product[ftsa_pkg::SCALE_FRAC +: ftsa_pkg::DELTA_W];

  // Credit saturates at fixed_step * max_steps
  assign credit_cap = mul_res.product[ftsa_pkg::CREDIT_W-1:0];
  assign credit_sum = (ftsa_pkg::DELTA_W + 1)'(credit) + (ftsa_pkg::DELTA_W + 1)'(last_delta);
  assign credit_sat = (credit_sum > (ftsa_pkg::DELTA_W + 1)'(credit_cap)) ? credit_cap :
                      credit_sum[ftsa_pkg::CREDIT_W-1:0];

  ftsa_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .res (mul_res)
  );

  ftsa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ftsa_pkg::S_IDLE: begin
        if (accept) begin
          state_next = frame_go ? ftsa_pkg::S_MUL_DELTA : ftsa_pkg::S_ALPHA_START;
        end
      end
      ftsa_pkg::S_MUL_DELTA: begin
        if (mul_res.done) begin
          state_next = ftsa_pkg::S_MUL_CAP;
        end
      end
      ftsa_pkg::S_MUL_CAP: begin
        if (mul_res.done) begin
          state_next = step_zero ? ftsa_pkg::S_ALPHA_START : ftsa_pkg::S_DIV_STEPS;
        end
      end
      ftsa_pkg::S_DIV_STEPS: begin
        if (div_res.done) begin
          state_next = ftsa_pkg::S_ALPHA_START;
        end
      end
      ftsa_pkg::S_ALPHA_START: begin
        if (step_zero || (credit >= ftsa_pkg::CREDIT_W'(fixed_step))) begin
          state_next = ftsa_pkg::S_DONE;
        end else begin
          state_next = ftsa_pkg::S_ALPHA_WAIT;
        end
      end
      ftsa_pkg::S_ALPHA_WAIT: begin
        if (div_res.done) begin
          state_next = ftsa_pkg::S_DONE;
        end
      end
      ftsa_pkg::S_DONE: begin
        if (out_load) begin
          state_next = ftsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ftsa_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: handshake and unit requests
  always_comb begin
    in_stall         = (state != ftsa_pkg::S_IDLE);
    mul_req.start    = 1'b0;
    mul_req.a        = sim_delta;
    mul_req.b        = time_scale;
    div_req.start    = 1'b0;
    div_req.divisor  = fixed_step;
    div_req.rem_init = credit_sat[ftsa_pkg::CREDIT_W-1 -: ftsa_pkg::STEP_W];
    div_req.low_bits = {credit_sat[ftsa_pkg::MAX_STEPS_W-1:0],
                        (ftsa_pkg::DIV_Q_W - ftsa_pkg::MAX_STEPS_W)'(0)};
    div_req.iters    = ftsa_pkg::DIV_CNT_W'(ftsa_pkg::MAX_STEPS_W);
    case (state)
      ftsa_pkg::S_IDLE: begin
        mul_req.start = accept && frame_go;
      end
      ftsa_pkg::S_MUL_DELTA: begin
        // Second pass forms the credit cap
        mul_req.start = mul_res.done;
        mul_req.a     = ftsa_pkg::MUL_A_W'(fixed_step);
        mul_req.b     = ftsa_pkg::MUL_B_W'(max_steps);
      end
      ftsa_pkg::S_MUL_CAP: begin
        // Credit is below 256 steps, so its top bits start below the divisor
        div_req.start = mul_res.done && !step_zero;
      end
      ftsa_pkg::S_ALPHA_START: begin
        div_req.start    = !step_zero && (credit < ftsa_pkg::CREDIT_W'(fixed_step));
        div_req.rem_init = credit[ftsa_pkg::STEP_W-1:0];
        div_req.low_bits = '0;
        div_req.iters    = ftsa_pkg::DIV_CNT_W'(ftsa_pkg::ALPHA_W);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ftsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_step     <= ftsa_pkg::RST_FIXED_STEP;
      max_delta      <= ftsa_pkg::RST_MAX_DELTA;
      max_steps      <= ftsa_pkg::RST_MAX_STEPS;
      max_scale      <= ftsa_pkg::RST_MAX_SCALE;
      playing        <= 1'b0;
      paused         <= 1'b0;
      time_scale     <= ftsa_pkg::SCALE_ONE;
      credit         <= '0;
      scaled_total   <= '0;
      unscaled_total <= '0;
      frames         <= '0;
      last_delta     <= '0;
      last_unscaled  <= '0;
      last_steps     <= '0;
    end else begin
      if (cfg_we) begin
        case (ftsa_pkg::cfg_idx_t'(cfg_index))
          ftsa_pkg::CFG_FIXED_STEP: fixed_step <= cfg_data[ftsa_pkg::STEP_W-1:0];
          ftsa_pkg::CFG_MAX_DELTA:  max_delta  <= cfg_data[ftsa_pkg::MAX_DELTA_W-1:0];
          ftsa_pkg::CFG_MAX_STEPS:  max_steps  <= cfg_data[ftsa_pkg::MAX_STEPS_W-1:0];
          ftsa_pkg::CFG_MAX_SCALE:  max_scale  <= cfg_data[ftsa_pkg::SCALE_W-1:0];
          default: begin
          end
        endcase
      end

      case (state)
        ftsa_pkg::S_IDLE: begin
          if (accept) begin
            case (ftsa_pkg::op_t'(in_data.op))
              ftsa_pkg::OP_FRAME: begin
                last_steps <= '0;
                if (!playing) begin
                  last_delta    <= '0;
                  last_unscaled <= '0;
                end else begin
                  // Unscaled time and frame count advance even while paused
                  last_unscaled  <= frame_delta;
                  unscaled_total <= unscaled_total + ftsa_pkg::TOTAL_W'(frame_delta);
                  frames         <= frames + 1'b1;
                  if (paused) begin
                    last_delta <= '0;
                  end
                end
              end
              ftsa_pkg::OP_PLAY, ftsa_pkg::OP_RESET: begin
                playing        <= (ftsa_pkg::op_t'(in_data.op) == ftsa_pkg::OP_PLAY);
                paused         <= 1'b0;
                time_scale     <= ftsa_pkg::SCALE_ONE;
                credit         <= '0;
                scaled_total   <= '0;
                unscaled_total <= '0;
                frames         <= '0;
                last_delta     <= '0;
                last_unscaled  <= '0;
                last_steps     <= '0;
              end
              ftsa_pkg::OP_STOP: begin
                playing       <= 1'b0;
                paused        <= 1'b0;
                credit        <= '0;
                last_delta    <= '0;
                last_unscaled <= '0;
                last_steps    <= '0;
              end
              ftsa_pkg::OP_PAUSE, ftsa_pkg::OP_RESUME: begin
                // Ignore pause and resume outside play
                if (playing) begin
                  paused     <= (ftsa_pkg::op_t'(in_data.op) == ftsa_pkg::OP_PAUSE);
                  last_delta <= '0;
                  last_steps <= '0;
                end
              end
              ftsa_pkg::OP_DISCARD: begin
                credit     <= '0;
                last_steps <= '0;
              end
              ftsa_pkg::OP_SCALE: begin
                time_scale <= scale_clamped;
              end
              default: begin
              end
            endcase
          end
        end
        ftsa_pkg::S_MUL_DELTA: begin
          if (mul_res.done) begin
            last_delta   <= prod_delta;
            scaled_total <= scaled_total + ftsa_pkg::TOTAL_W'(prod_delta);
          end
        end
        ftsa_pkg::S_MUL_CAP: begin
          if (mul_res.done) begin
            credit <= credit_sat;
          end
        end
        ftsa_pkg::S_DIV_STEPS: begin
          if (div_res.done) begin
            last_steps <= div_res.quotient[ftsa_pkg::MAX_STEPS_W-1:0];
            credit     <= ftsa_pkg::CREDIT_W'(div_res.remainder);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Alpha: zero without a step, saturated when the credit holds a whole step
  always_ff @(posedge clk) begin
    case (state)
      ftsa_pkg::S_ALPHA_START: begin
        if (step_zero) begin
          alpha <= '0;
        end else if (credit >= ftsa_pkg::CREDIT_W'(fixed_step)) begin
          alpha <= '1;
        end
      end
      ftsa_pkg::S_ALPHA_WAIT: begin
        if (div_res.done) begin
          alpha <= div_res.quotient;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register; hold it while the far side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.delta_us_res      <= last_delta;
      out_data.unscaled_delta_us <= last_unscaled;
      out_data.fixed_steps       <= last_steps;
      out_data.time_us           <= scaled_total;
      out_data.unscaled_time_us  <= unscaled_total;
      out_data.frame_count       <= frames;
      out_data.alpha_q16         <= alpha;
      out_data.is_playing        <= playing;
      out_data.is_paused         <= paused;
    end
  end

  // The step division leaves less than one step of credit
  a_credit_below_step: assert property (@(posedge clk) disable iff (rst)
    (state == ftsa_pkg::S_DIV_STEPS) && div_res.done |=>
      (credit < ftsa_pkg::CREDIT_W'(fixed_step)))
    else $error("credit not below one step after step division");

  // Every accepted item leaves idle on the next cycle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ftsa_pkg::S_IDLE))
    else $error("accepted item did not start");

  // Multiplier results arrive only while a multiply pass is expected
  a_mul_done_in_pass: assert property (@(posedge clk) disable iff (rst)
    mul_res.done |-> (state == ftsa_pkg::S_MUL_DELTA) || (state == ftsa_pkg::S_MUL_CAP))
    else $error("stray multiplier result");

  // Paused implies playing, both in state and in a delivered result
  a_paused_playing: assert property (@(posedge clk) disable iff (rst)
    (!paused || playing) && (!out_valid || !out_data.is_paused || out_data.is_playing))
    else $error("paused without play");

endmodule

>>> rtl/ftsa_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps

module ftsa_mul (
  input  logic                clk,
  input  logic                rst,
  input  ftsa_pkg::mul_req_t  req,
  output ftsa_pkg::mul_res_t  res
);

  logic                             busy;
  logic                             done;
  logic [ftsa_pkg::MUL_CNT_W-1:0]   cnt;
  logic [ftsa_pkg::MUL_P_W-1:0]     acc;
  logic [ftsa_pkg::MUL_P_W-1:0]     mcand;
  logic [ftsa_pkg::MUL_B_W-1:0]     mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ftsa_pkg::MUL_CNT_W'(ftsa_pkg::MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc    <= '0;
      mcand  <= ftsa_pkg::MUL_P_W'(req.a);
      mplier <= req.b;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign res.done    = done;
  assign res.product = acc;

endmodule

>>> rtl/ftsa_div.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ftsa_div (
  input  logic                clk,
  input  logic                rst,
  input  ftsa_pkg::div_req_t  req,
  output ftsa_pkg::div_res_t  res
);

  logic                             busy;
  logic                             done;
  logic [ftsa_pkg::DIV_CNT_W-1:0]   cnt;
  logic [ftsa_pkg::STEP_W-1:0]      divisor;
  logic [ftsa_pkg::STEP_W-1:0]      rem;
  logic [ftsa_pkg::DIV_Q_W-1:0]     low_bits;
  logic [ftsa_pkg::DIV_Q_W-1:0]     quot;
  logic [ftsa_pkg::STEP_W:0]        trial;
  logic                             fits;

  // Bring down the next dividend bit and try one subtraction
  assign trial = {rem, low_bits[ftsa_pkg::DIV_Q_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ftsa_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor  <= req.divisor;
      rem      <= req.rem_init;
      low_bits <= req.low_bits;
      quot     <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= ftsa_pkg::STEP_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[ftsa_pkg::STEP_W-1:0];
      end
      quot     <= {quot[ftsa_pkg::DIV_Q_W-2:0], fits};
      low_bits <= low_bits << 1;
    end
  end

  assign res.done      = done;
  assign res.quotient  = quot;
  assign res.remainder = rem;

endmodule

>>> tb/tb_fixed_timestep_accumulator_core.sv
// Self-checking testbench for the fixed-timestep accumulator core.
`timescale 1ns / 1ps

module tb_fixed_timestep_accumulator_core;
  import ftsa_pkg::*;

  localparam int DIR_N       = 25;
  localparam int PHASES      = 8;
  localparam int RAND_PER_PH = 243;
  localparam int SETTLE_CYC  = 64;

  // One row of the directed table. Rows marked typed carry a result that can be
  // read off by hand; all other rows are checked against the predictor.
  typedef struct {
    op_t       op;
    int        delta;
    int        scale;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  fixed_timestep_accumulator_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: the slowest correct run is well under 2 ms.
  initial begin
    #20_000_000;
    $display("tb_fixed_timestep_accumulator_core failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: register copies and run state at the block's own widths
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0]      step_us;
  logic [MAX_DELTA_W-1:0] delta_cap;
  logic [MAX_STEPS_W-1:0] steps_cap;
  logic [SCALE_W-1:0]     scale_cap;

  logic                   run_on;
  logic                   run_paused;
  logic [SCALE_W-1:0]     scale_now;
  logic [CREDIT_W-1:0]    credit_us;
  logic [TOTAL_W-1:0]     sim_total;
  logic [TOTAL_W-1:0]     wall_total;
  logic [FRAMES_W-1:0]    frame_total;
  logic [DELTA_W-1:0]     cur_delta;
  logic [MAX_DELTA_W-1:0] cur_raw;
  logic [MAX_STEPS_W-1:0] cur_steps;

  out_item_t pending_results[$];

  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int step_frames   = 0;
  int settings_used = 0;
  bit no_idle       = 1'b0;

  // Clear everything a new run starts from; play flag is left to the caller.
  task automatic restart_run();
    credit_us   = '0;
    sim_total   = '0;
    wall_total  = '0;
    frame_total = '0;
    cur_delta   = '0;
    cur_raw     = '0;
    cur_steps   = '0;
    scale_now   = SCALE_ONE;
    run_paused  = 1'b0;
  endtask

  // Advance the predicted state by one transfer and form the result it shows.
  task automatic step_accumulator(input in_item_t it, output out_item_t r);
    logic [MAX_DELTA_W-1:0] d;
    logic [SCALE_W-1:0]     req;
    logic [63:0]            sim;
    logic [63:0]            prod;
    logic [63:0]            cap;
    logic [63:0]            c;
    logic [63:0]            n;
    logic [63:0]            a;
    case (it.op)
      OP_FRAME: begin
        cur_steps = '0;
        if (!run_on) begin
          cur_delta = '0;
          cur_raw   = '0;
        end else begin
          // negative deltas count as zero
          d           = it.delta_us[RAW_DELTA_W-1] ? '0 : it.delta_us[MAX_DELTA_W-1:0];
          cur_raw     = d;
          wall_total  = wall_total + d;
          frame_total = frame_total + 1'b1;
          if (run_paused) begin
            cur_delta = '0;
          end else begin
            sim       = (d < delta_cap) ? 64'(d) : 64'(delta_cap);
            prod      = (sim * scale_now) >> SCALE_FRAC;
            cur_delta = prod[DELTA_W-1:0];
            sim_total = sim_total + cur_delta;
            cap       = 64'(step_us) * 64'(steps_cap);
            c         = 64'(credit_us) + 64'(cur_delta);
            if (c > cap) c = cap;
            n = '0;
            if (step_us != '0) begin
              n = c / step_us;
              if (n > steps_cap) n = steps_cap;
              c = c - n * step_us;
            end
            credit_us = c[CREDIT_W-1:0];
            cur_steps = n[MAX_STEPS_W-1:0];
          end
        end
      end
      OP_PLAY: begin
        restart_run();
        run_on = 1'b1;
      end
      OP_STOP: begin
        cur_delta  = '0;
        cur_raw    = '0;
        credit_us  = '0;
        cur_steps  = '0;
        run_on     = 1'b0;
        run_paused = 1'b0;
      end
      OP_PAUSE, OP_RESUME: begin
        // ignored unless a run is in progress
        if (run_on) begin
          cur_delta  = '0;
          cur_steps  = '0;
          run_paused = (it.op == OP_PAUSE);
        end
      end
      OP_DISCARD: begin
        credit_us = '0;
        cur_steps = '0;
      end
      OP_RESET: begin
        run_on = 1'b0;
        restart_run();
      end
      default: begin
        // clamp the signed request to 0 .. max scale
        req = it.scale_q8;
        if (req[SCALE_W-1]) scale_now = '0;
        else scale_now = (req < scale_cap) ? req : scale_cap;
      end
    endcase
    a = '0;
    if (step_us != '0) begin
      a = (64'(credit_us) << ALPHA_W) / step_us;
      if (a > 64'hFFFF) a = 64'hFFFF;
    end
    r                   = '0;
    r.delta_us_res      = cur_delta;
    r.unscaled_delta_us = cur_raw;
    r.fixed_steps       = cur_steps;
    r.time_us           = sim_total;
    r.unscaled_time_us  = wall_total;
    r.frame_count       = frame_total;
    r.alpha_q16         = a[ALPHA_W-1:0];
    r.is_playing        = run_on;
    r.is_paused         = run_paused;
  endtask

  function automatic out_item_t plain_res(input int frames, input bit playing);
    out_item_t r;
    r             = '0;
    r.frame_count = FRAMES_W'(frames);
    r.is_playing  = playing;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: random gap, then hold the transfer until it is taken
  // ---------------------------------------------------------------------------
  task automatic send_event(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t r;
    // switch between idling and back-to-back stretches now and then
    if (items_sent % 97 == 0) no_idle = ($urandom_range(0, 3) == 0);
    gap = no_idle ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    step_accumulator(it, r);
    pending_results.push_back(typed ? want : r);
    items_sent++;
  endtask

  // Drop valid and wait until every result is in and the core has settled.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // One register write; cfg_we stays up across back-to-back writes.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_FIXED_STEP: step_us   = val[STEP_W-1:0];
      CFG_MAX_DELTA:  delta_cap = val[MAX_DELTA_W-1:0];
      CFG_MAX_STEPS:  steps_cap = val[MAX_STEPS_W-1:0];
      default:        scale_cap = val[SCALE_W-1:0];
    endcase
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] fs, input logic [CFG_W-1:0] md,
                               input logic [CFG_W-1:0] ms, input logic [CFG_W-1:0] sc);
    drain();
    write_reg(CFG_FIXED_STEP, fs);
    write_reg(CFG_MAX_DELTA, md);
    write_reg(CFG_MAX_STEPS, ms);
    write_reg(CFG_MAX_SCALE, sc);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Mostly frames during play with deltas near the step length; commands and
  // odd deltas mixed in. When stopped, favor starting a new run.
  function automatic in_item_t rand_event();
    in_item_t it;
    int       pick;
    int       v;
    it.op       = OP_FRAME;
    it.delta_us = RAW_DELTA_W'($urandom);
    it.scale_q8 = SCALE_W'($urandom);
    pick = $urandom_range(0, 99);
    if (!run_on && pick < 40) it.op = OP_PLAY;
    else if (pick < 68)       it.op = OP_FRAME;
    else if (pick < 72)       it.op = OP_PLAY;
    else if (pick < 75)       it.op = OP_STOP;
    else if (pick < 79)       it.op = OP_PAUSE;
    else if (pick < 84)       it.op = OP_RESUME;
    else if (pick < 87)       it.op = OP_DISCARD;
    else if (pick < 89)       it.op = OP_RESET;
    else                      it.op = OP_SCALE;
    case ($urandom_range(0, 9))
      0: ;  // full random bits
      1: it.delta_us = RAW_DELTA_W'(-$urandom_range(1, 8388608));
      2: begin
        case ($urandom_range(0, 3))
          0:       v = 8388607;
          1:       v = 0;
          2:       v = delta_cap;
          default: v = delta_cap + 1;
        endcase
        it.delta_us = RAW_DELTA_W'(v > 8388607 ? 8388607 : v);
      end
      3, 4: begin
        v = step_us * $urandom_range(0, 3) + $urandom_range(0, 3);
        it.delta_us = RAW_DELTA_W'((v > 8388607 || v < 0) ? 8388607 : v);
      end
      default: begin
        v = $urandom_range(0, 2 * step_us + 100);
        it.delta_us = RAW_DELTA_W'((v > 8388607 || v < 0) ? 8388607 : v);
      end
    endcase
    if ($urandom_range(0, 3) != 0) it.scale_q8 = SCALE_W'($urandom_range(0, 1024));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t           dir_tab [DIR_N];
    in_item_t           it;
    logic [CFG_W-1:0]   cfg_sets [PHASES][4];

    step_us   = RST_FIXED_STEP;
    delta_cap = RST_MAX_DELTA;
    steps_cap = RST_MAX_STEPS;
    scale_cap = RST_MAX_SCALE;
    run_on    = 1'b0;
    restart_run();

    dir_tab = '{
      '{OP_FRAME,   100,      0,      1'b1, plain_res(0, 0)},  // frame while stopped
      '{OP_PLAY,    0,        0,      1'b1, plain_res(0, 1)},
      '{OP_FRAME,   -8388608, 0,      1'b1, plain_res(1, 1)},  // most negative delta
      '{OP_FRAME,   0,        0,      1'b1, plain_res(2, 1)},
      '{OP_FRAME,   8388607,  0,      1'b0, '0},               // capped, credit saturates
      '{OP_FRAME,   16667,    0,      1'b0, '0},
      '{OP_FRAME,   20000,    0,      1'b0, '0},
      '{OP_PAUSE,   0,        0,      1'b0, '0},
      '{OP_FRAME,   5000,     0,      1'b0, '0},               // frame while paused
      '{OP_PAUSE,   0,        0,      1'b0, '0},
      '{OP_RESUME,  0,        0,      1'b0, '0},
      '{OP_SCALE,   0,        32767,  1'b0, '0},               // clamped to max scale
      '{OP_FRAME,   1000,     0,      1'b0, '0},
      '{OP_SCALE,   0,        -32768, 1'b0, '0},               // negative scale -> 0
      '{OP_FRAME,   3000,     0,      1'b0, '0},
      '{OP_SCALE,   0,        128,    1'b0, '0},
      '{OP_FRAME,   33333,    0,      1'b0, '0},
      '{OP_DISCARD, 0,        0,      1'b0, '0},
      '{OP_STOP,    0,        0,      1'b0, '0},
      '{OP_PAUSE,   0,        0,      1'b0, '0},               // pause while stopped
      '{OP_RESUME,  0,        0,      1'b0, '0},
      '{OP_FRAME,   -1,       0,      1'b0, '0},
      '{OP_SCALE,   0,        512,    1'b0, '0},               // scale while stopped
      '{OP_RESET,   0,        0,      1'b0, '0},
      '{OP_PLAY,    0,        0,      1'b1, plain_res(0, 1)}
    };

    // step, delta cap, max steps, max scale; zero step and zero max steps are
    // outside the documented ranges but still legal encodings
    cfg_sets = '{
      '{23'd16667,   23'd250000,  23'd8,   23'd25600},
      '{23'd1,       23'd8388607, 23'd255, 23'd65535},
      '{23'd1048575, 23'd8388607, 23'd1,   23'd65535},
      '{23'd0,       23'd1000,    23'd4,   23'd256},
      '{23'd100,     23'd0,       23'd255, 23'd512},
      '{23'd5000,    23'd20000,   23'd0,   23'd1024},
      '{23'd0,       23'd0,       23'd0,   23'd0},
      '{23'd16667,   23'd250000,  23'd8,   23'd0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part runs on the reset register values
    foreach (dir_tab[i]) begin
      it          = '0;
      it.op       = dir_tab[i].op;
      it.delta_us = RAW_DELTA_W'(dir_tab[i].delta);
      it.scale_q8 = SCALE_W'(dir_tab[i].scale);
      send_event(it, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 6) begin
        // fully random register contents, upper write bits included
        for (int k = 0; k < 4; k++) cfg_sets[ph][k] = CFG_W'($urandom);
      end
      load_settings(cfg_sets[ph][0], cfg_sets[ph][1], cfg_sets[ph][2], cfg_sets[ph][3]);
      repeat (RAND_PER_PH) send_event(rand_event(), 1'b0, '0);
    end

    drain();
    $display("%0d events over %0d register settings; %0d results checked, %0d with steps",
             items_sent, settings_used, results_seen, step_frames);
    if (errors == 0) begin
      $display("tb_fixed_timestep_accumulator_core passed");
    end else begin
      $display("tb_fixed_timestep_accumulator_core failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random stall before each transfer, then check it
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    int        hold;
    out_item_t want;
    wait (rst === 1'b0);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 3);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_seen++;
      if (out_data.fixed_steps != '0) step_frames++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("delta_us_res", want.delta_us_res, out_data.delta_us_res);
        check_field("unscaled_delta_us", want.unscaled_delta_us, out_data.unscaled_delta_us);
        check_field("fixed_steps", want.fixed_steps, out_data.fixed_steps);
        check_field("time_us", want.time_us, out_data.time_us);
        check_field("unscaled_time_us", want.unscaled_time_us, out_data.unscaled_time_us);
        check_field("frame_count", want.frame_count, out_data.frame_count);
        check_field("alpha_q16", want.alpha_q16, out_data.alpha_q16);
        check_field("is_playing", want.is_playing, out_data.is_playing);
        check_field("is_paused", want.is_paused, out_data.is_paused);
      end
    end
  end

endmodule
